FILE: rtl/hpt_pkg.sv
// Shared types and constants of the host presence tracker.
package hpt_pkg;

  localparam int IpW  = 32;
  localparam int MacW = 48;

  typedef enum logic {
    CMD_OBSERVE = 1'b0,
    CMD_TICK    = 1'b1
  } hpt_cmd_e;

  typedef struct packed {
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } hpt_entry_t;

  typedef struct packed {
    logic wr;
    logic shift;
    logic roll;
  } hpt_row_ctl_t;

endpackage

FILE: rtl/hpt_cmd_if.sv
// Command channel: observe or tick transactions into the tracker.
interface hpt_cmd_if import hpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            command;
  logic [IpW-1:0]  host_ip;
  logic [MacW-1:0] host_mac;

  modport source (output valid, command, host_ip, host_mac, input ready);
  modport sink   (input valid, command, host_ip, host_mac, output ready);
endinterface

FILE: rtl/hpt_gone_if.sv
// Departure channel: one transaction per host absent this period.
interface hpt_gone_if import hpt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IpW-1:0]  gone_ip;
  logic [MacW-1:0] gone_mac;
  logic            last_of_run;

  modport source (output valid, gone_ip, gone_mac, last_of_run, input ready);
  modport sink   (input valid, gone_ip, gone_mac, last_of_run, output ready);
endinterface

FILE: rtl/hpt_cell.sv
// One table cell: a current entry, a previous entry and a match compare.
module hpt_cell import hpt_pkg::*; (
  input  logic         clk_i,
  input  hpt_row_ctl_t ctl_i,
  input  logic         sel_i,
  input  logic         live_i,
  input  hpt_entry_t   key_i,
  input  hpt_entry_t   nbr_i,
  output logic         hit_o,
  output hpt_entry_t   prev_o
);

  hpt_entry_t cur_q;
  hpt_entry_t prev_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && sel_i) begin
      cur_q <= key_i;
    end
    if (ctl_i.roll) begin
      prev_q <= cur_q;
    end else if (ctl_i.shift) begin
      prev_q <= nbr_i;
    end
  end

  assign hit_o  = live_i && (cur_q == key_i);
  assign prev_o = prev_q;

endmodule

FILE: rtl/hpt_cell_row.sv
// Row of table cells; previous entries shift towards cell zero.
module hpt_cell_row import hpt_pkg::*; #(
  parameter int Depth = 32,
  parameter int CntW  = 6
) (
  input  logic            clk_i,
  input  hpt_row_ctl_t    ctl_i,
  input  logic [CntW-1:0] cur_cnt_i,
  input  hpt_entry_t      key_i,
  output logic            any_hit_o,
  output hpt_entry_t      head_o
);

  logic [Depth-1:0] hit;
  hpt_entry_t       prev [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    hpt_entry_t nbr;
    if (i == Depth - 1) begin : g_tail
      assign nbr = prev[i];
    end else begin : g_mid
      assign nbr = prev[i+1];
    end

    hpt_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl_i),
      .sel_i  (cur_cnt_i == CntW'(i)),
      .live_i (CntW'(i) < cur_cnt_i),
      .key_i  (key_i),
      .nbr_i  (nbr),
      .hit_o  (hit[i]),
      .prev_o (prev[i])
    );
  end

  assign any_hit_o = |hit;
  assign head_o    = prev[0];

endmodule

FILE: rtl/host_presence_tracker_unit.sv
// Top level of the host presence tracker.
//
//   channel  dir  payload                              handshake
//   cmd_i    in   command, host_ip, host_mac           valid / ready
//   gone_o   out  gone_ip, gone_mac, last_of_run       valid / ready
//
// An observe is accepted, then compared in parallel across all cells and inserted.
// A tick walks the previous table's entries: one cell shift per entry,
// each compared against the current table, then one roll-over.
// A departure stalls the walk only while the output register is full and not taken.
// Reset empties both tables by clearing the fill counts; cell contents are not cleared.
module host_presence_tracker_unit import hpt_pkg::*; #(
  parameter int TABLE_DEPTH = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  hpt_cmd_if.sink   cmd_i,
  hpt_gone_if.source gone_o
);

  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OBS,
    ST_WALK
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cur_cnt_q;
  logic [CntW-1:0] prev_cnt_q;
  logic [CntW-1:0] rem_q;
  logic            pend_vld_q;
  logic            out_vld_q;
  logic            out_last_q;
  hpt_entry_t      key_q;
  hpt_entry_t      pend_q;
  hpt_entry_t      out_q;

  hpt_entry_t   key;
  hpt_entry_t   head;
  hpt_row_ctl_t ctl;
  logic         any_hit;
  logic         accept;
  logic         out_free;
  logic         need_push;
  logic         step;
  logic         finish;
  logic         insert;

  assign accept    = cmd_i.valid && cmd_i.ready;
  assign out_free  = !out_vld_q || gone_o.ready;
  assign need_push = !any_hit && pend_vld_q;
  assign step      = (state_q == ST_WALK) && (rem_q != '0) && (!need_push || out_free);
  assign finish    = (state_q == ST_WALK) && (rem_q == '0) && (!pend_vld_q || out_free);
  assign insert    = (state_q == ST_OBS) && !any_hit && (cur_cnt_q != CntW'(TABLE_DEPTH));
  assign key       = (state_q == ST_WALK) ? head : key_q;

  always_comb begin
    ctl       = '0;
    ctl.wr    = insert;
    ctl.shift = step;
    ctl.roll  = finish;
  end

  hpt_cell_row #(
    .Depth (TABLE_DEPTH),
    .CntW  (CntW)
  ) u_row (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .cur_cnt_i (cur_cnt_q),
    .key_i     (key),
    .any_hit_o (any_hit),
    .head_o    (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_cnt_q  <= '0;
      prev_cnt_q <= '0;
      rem_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (gone_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (cmd_i.command == CMD_TICK) ? ST_WALK : ST_OBS;
            rem_q   <= prev_cnt_q;
          end
        end
        ST_OBS: begin
          state_q <= ST_IDLE;
          if (insert) begin
            cur_cnt_q <= cur_cnt_q + 1'b1;
          end
        end
        ST_WALK: begin
          if (step) begin
            rem_q <= rem_q - 1'b1;
            if (!any_hit) begin
              pend_vld_q <= 1'b1;
            end
            if (need_push) begin
              out_vld_q <= 1'b1;
            end
          end
          if (finish) begin
            if (pend_vld_q) begin
              out_vld_q <= 1'b1;
            end
            pend_vld_q <= 1'b0;
            prev_cnt_q <= cur_cnt_q;
            cur_cnt_q  <= '0;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q.ip  <= cmd_i.host_ip;
      key_q.mac <= cmd_i.host_mac;
    end
    if (step && !any_hit) begin
      pend_q <= head;
    end
    if (step && need_push) begin
      out_q      <= pend_q;
      out_last_q <= 1'b0;
    end else if (finish && pend_vld_q) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
  end

  assign cmd_i.ready        = (state_q == ST_IDLE);
  assign gone_o.valid       = out_vld_q;
  assign gone_o.gone_ip     = out_q.ip;
  assign gone_o.gone_mac    = out_q.mac;
  assign gone_o.last_of_run = out_last_q;

endmodule

FILE: rtl/hpt_checker.sv
// Port-level checks of the tracker and their binding to the top level.
module hpt_checker import hpt_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cmd_valid_i,
  input logic            cmd_ready_i,
  input logic            cmd_command_i,
  input logic            gone_valid_i,
  input logic            gone_ready_i,
  input logic [IpW-1:0]  gone_ip_i,
  input logic [MacW-1:0] gone_mac_i,
  input logic            gone_last_i
);

  logic cmd_acc;
  logic gone_acc;

  assign cmd_acc  = cmd_valid_i && cmd_ready_i;
  assign gone_acc = gone_valid_i && gone_ready_i;

  a_gone_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gone_valid_i && !gone_ready_i |=> gone_valid_i && $stable(gone_ip_i) &&
      $stable(gone_mac_i) && $stable(gone_last_i))
    else $error("departure dropped or changed while stalled");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> !cmd_ready_i)
    else $error("next command taken before the previous one finished");

  a_observe_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc && (cmd_command_i == CMD_OBSERVE) |=> !$rose(gone_valid_i))
    else $error("observe produced a departure");

  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gone_acc && !gone_last_i |-> !cmd_ready_i)
    else $error("command accepted while a departure run is still open");

endmodule

bind host_presence_tracker_unit hpt_checker u_hpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .cmd_command_i (cmd_i.command),
  .gone_valid_i  (gone_o.valid),
  .gone_ready_i  (gone_o.ready),
  .gone_ip_i     (gone_o.gone_ip),
  .gone_mac_i    (gone_o.gone_mac),
  .gone_last_i   (gone_o.last_of_run)
);

FILE: tb/host_presence_tracker_unit_tb.sv
// Testbench of the host presence tracker: queued observe/tick stimulus, predicted departures.
`timescale 1ns / 1ps

module host_presence_tracker_unit_tb;
  import hpt_pkg::*;

  localparam int TableDepth = 32;
  localparam int PoolSize   = 40;
  localparam int ItemTarget = 265;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 4000;
  localparam int DrainCycles = 64;

  typedef struct {
    hpt_cmd_e        cmd;
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
  } host_cmd_t;

  typedef struct {
    logic [IpW-1:0]  ip;
    logic [MacW-1:0] mac;
    logic            last;
  } departure_t;

  logic clk = 1'b0;
  logic rst_n;

  hpt_cmd_if  cmd_bus ();
  hpt_gone_if gone_bus ();

  host_presence_tracker_unit #(
    .TABLE_DEPTH(TableDepth)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_bus.sink),
    .gone_o(gone_bus.source)
  );

  host_cmd_t  pending_cmds[$];
  departure_t expected_departures[$];
  hpt_entry_t hosts_this_period[$];
  hpt_entry_t hosts_last_period[$];
  hpt_entry_t host_pool[PoolSize];

  int send_gap = 0;
  int take_gap = 0;
  bit send_calm = 1'b0;
  bit take_calm = 1'b1;
  bit hold_off;
  int cmds_taken = 0;
  int mismatch_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0) calm = !calm;
    return calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  function automatic bit seen_this_period(hpt_entry_t h);
    foreach (hosts_this_period[k])
      if (hosts_this_period[k] == h) return 1'b1;
    return 1'b0;
  endfunction

  task automatic track_command(host_cmd_t c);
    hpt_entry_t h;
    hpt_entry_t gone[$];
    departure_t d;
    h.ip  = c.ip;
    h.mac = c.mac;
    if (c.cmd == CMD_OBSERVE) begin
      if (!seen_this_period(h) && hosts_this_period.size() < TableDepth)
        hosts_this_period = {hosts_this_period, h};
    end else begin
      foreach (hosts_last_period[k])
        if (!seen_this_period(hosts_last_period[k])) gone = {gone, hosts_last_period[k]};
      foreach (gone[k]) begin
        d.ip   = gone[k].ip;
        d.mac  = gone[k].mac;
        d.last = (k == gone.size() - 1);
        expected_departures = {expected_departures, d};
      end
      hosts_last_period = hosts_this_period;
      hosts_this_period.delete();
    end
  endtask

  task automatic note_mismatch(string what, departure_t want, departure_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t departure %s: expected ip=%h mac=%h last=%b, got ip=%h mac=%h last=%b",
               $time, what, want.ip, want.mac, want.last, got.ip, got.mac, got.last);
  endtask

  task automatic queue_cmd(hpt_cmd_e c, logic [IpW-1:0] ip, logic [MacW-1:0] mac);
    host_cmd_t item;
    item.cmd = c;
    item.ip  = ip;
    item.mac = mac;
    pending_cmds = {pending_cmds, item};
  endtask

  function automatic hpt_entry_t fresh_host();
    hpt_entry_t h;
    h.ip  = $urandom;
    h.mac = {16'($urandom), 32'($urandom)};
    return h;
  endfunction

  function automatic hpt_entry_t pick_host(bit spread);
    hpt_entry_t h;
    int r;
    r = $urandom_range(0, 9);
    if ((spread && r < 5) || r == 0) begin
      h = fresh_host();
      host_pool[$urandom_range(0, PoolSize - 1)] = h;
    end else begin
      h = host_pool[$urandom_range(0, PoolSize - 1)];
      if (r == 1) h.mac = {16'($urandom), 32'($urandom)};
      else if (r == 2) h.ip = $urandom;
    end
    return h;
  endfunction

  always @(posedge clk) begin
    bit taken;
    if (rst_n) begin
      taken = cmd_bus.valid && cmd_bus.ready;
      if (taken) begin
        track_command(pending_cmds.pop_front());
        cmds_taken++;
        send_gap = draw_wait(send_calm);
      end
      if (taken || !cmd_bus.valid) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_bus.valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cmd_bus.valid    <= 1'b1;
          cmd_bus.command  <= pending_cmds[0].cmd;
          cmd_bus.host_ip  <= pending_cmds[0].ip;
          cmd_bus.host_mac <= pending_cmds[0].mac;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    departure_t want;
    departure_t got;
    if (rst_n) begin
      if (gone_bus.valid && gone_bus.ready) begin
        got.ip   = gone_bus.gone_ip;
        got.mac  = gone_bus.gone_mac;
        got.last = gone_bus.last_of_run;
        if (expected_departures.size() == 0) begin
          want = '{default: '0};
          note_mismatch("unexpected", want, got);
        end else begin
          want = expected_departures.pop_front();
          if (got.ip !== want.ip || got.mac !== want.mac || got.last !== want.last)
            note_mismatch("mismatch", want, got);
        end
        take_gap = draw_wait(take_calm);
      end
      if (hold_off) begin
        gone_bus.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        gone_bus.ready <= 1'b0;
      end else begin
        gone_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    wait (cmds_taken >= 80);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n === 1'b1);
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (gone_bus.valid && gone_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    hpt_entry_t h;
    int period;
    int n;
    bit big;
    rst_n            = 1'b0;
    cmd_bus.valid    = 1'b0;
    cmd_bus.command  = CMD_OBSERVE;
    cmd_bus.host_ip  = '0;
    cmd_bus.host_mac = '0;
    gone_bus.ready   = 1'b0;

    foreach (host_pool[k]) host_pool[k] = fresh_host();

    queue_cmd(CMD_TICK, '0, '0);
    queue_cmd(CMD_OBSERVE, '0, '0);
    queue_cmd(CMD_OBSERVE, '1, '1);
    queue_cmd(CMD_OBSERVE, '0, '0);
    queue_cmd(CMD_OBSERVE, '1, '0);
    queue_cmd(CMD_OBSERVE, '0, '1);
    queue_cmd(CMD_TICK, '1, '1);
    queue_cmd(CMD_OBSERVE, '0, '0);
    queue_cmd(CMD_OBSERVE, 32'h0a00_0001, 48'h0200_0000_0001);
    queue_cmd(CMD_OBSERVE, 32'h0a00_0001, 48'h0200_0000_0001);
    queue_cmd(CMD_TICK, '0, '0);
    queue_cmd(CMD_TICK, 32'h8000_0000, 48'h8000_0000_0000);
    queue_cmd(CMD_TICK, '0, '0);

    period = 0;
    while (pending_cmds.size() < ItemTarget) begin
      big = (period == 2) || ($urandom_range(0, 7) == 0);
      n   = (period == 3) ? 0 : big ? $urandom_range(30, 40) : $urandom_range(0, 12);
      repeat (n) begin
        h = (period == 2) ? fresh_host() : pick_host(big);
        queue_cmd(CMD_OBSERVE, h.ip, h.mac);
      end
      h = fresh_host();
      queue_cmd(CMD_TICK, h.ip, h.mac);
      period++;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_cmds.size() > 0 || cmd_bus.valid || expected_departures.size() > 0);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
